### design/mcbf_pkg.sv
// Package for the multi-channel byte FIFO: item and result types, region
// descriptors, field widths, reset constants and the free-space function.
// Depends on nothing; every other file of the block imports it.
package mcbf_pkg;

	localparam int NUM_REGS        = 4;
	localparam int CH_W            = 2;
	localparam int DATA_W          = 8;
	localparam int SIZE_W          = 9;
	localparam int POS_W           = 8;
	localparam int BASE_W          = 10;
	localparam int END_W           = 11;
	localparam int CHANNELS_DEF    = 4;
	localparam int STORE_BYTES_DEF = 256;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd64;

	typedef enum logic {
		MODE_PUSH = 1'b0,
		MODE_POP  = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [CH_W-1:0]   channel;
		logic [DATA_W-1:0] data_in;
	} req_item_t;

	typedef struct packed {
		logic              accepted;
		logic [DATA_W-1:0] data_out;
		logic [SIZE_W-1:0] space_left;
	} rsp_item_t;

	typedef struct packed {
		logic              usable;
		logic [SIZE_W-1:0] size;
		logic [BASE_W-1:0] base;
	} region_t;

	typedef struct packed {
		logic              accepted;
		logic              pop_ok;
		logic [SIZE_W-1:0] space;
	} op_res_t;

	function automatic logic [SIZE_W-1:0] free_space(
		input logic [SIZE_W-1:0] size,
		input logic [POS_W-1:0]  wp,
		input logic [POS_W-1:0]  rp,
		input logic              empty
	);
		logic [SIZE_W-1:0] diff;
		logic [SIZE_W-1:0] res;
		diff = {1'b0, wp} - {1'b0, rp};
		if (empty) begin
			res = size;
		end else if (wp == rp) begin
			res = '0;
		end else if (wp > rp) begin
			res = size - diff;
		end else begin
			res = {1'b0, rp} - {1'b0, wp};
		end
		return res;
	endfunction

endpackage

### design/mcbf_cfg.sv
// Size registers of the multi-channel byte FIFO and the region layout
// derived from them (start offset and usable flag per channel).
// Depends on mcbf_pkg.
module mcbf_cfg #(
	parameter int CHANNELS    = mcbf_pkg::CHANNELS_DEF,
	parameter int STORE_BYTES = mcbf_pkg::STORE_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mcbf_pkg::CH_W-1:0]    cfg_index,
	input  logic [mcbf_pkg::SIZE_W-1:0]  cfg_wdata,
	output mcbf_pkg::region_t            regions [mcbf_pkg::NUM_REGS],
	output logic                         clear
);
	import mcbf_pkg::*;

	region_t           regions_q [NUM_REGS];
	logic [SIZE_W-1:0] nsize     [NUM_REGS];
	logic [BASE_W-1:0] nbase     [NUM_REGS];
	logic [END_W-1:0]  nend      [NUM_REGS];
	logic              write_ok;

	assign write_ok = cfg_we && (32'(cfg_index) < 32'(CHANNELS));
	assign clear    = write_ok;

	always_comb begin
		for (int c = 0; c < NUM_REGS; c++) begin
			nsize[c] = (cfg_index == CH_W'(c)) ? cfg_wdata : regions_q[c].size;
		end
		nbase[0] = '0;
		for (int c = 1; c < NUM_REGS; c++) begin
			nbase[c] = nbase[c-1] + BASE_W'(nsize[c-1]);
		end
		for (int c = 0; c < NUM_REGS; c++) begin
			nend[c] = END_W'(nbase[c]) + END_W'(nsize[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_REGS; c++) begin
				regions_q[c].size   <= SIZE_RESET;
				regions_q[c].base   <= BASE_W'(c * int'(SIZE_RESET));
				regions_q[c].usable <= (c < CHANNELS) &&
					((c + 1) * int'(SIZE_RESET) <= STORE_BYTES);
			end
		end else if (write_ok) begin
			for (int c = 0; c < NUM_REGS; c++) begin
				regions_q[c].size   <= nsize[c];
				regions_q[c].base   <= nbase[c];
				regions_q[c].usable <= (c < CHANNELS) && (nsize[c] != '0) &&
					(32'(nend[c]) <= 32'(STORE_BYTES));
			end
		end
	end

	assign regions = regions_q;

endmodule

### design/mcbf_store.sv
// Shared byte store of the multi-channel byte FIFO: one synchronous memory
// with a single address, a write enable and a registered read.
// Depends on mcbf_pkg.
module mcbf_store #(
	parameter int STORE_BYTES = mcbf_pkg::STORE_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic                           re,
	input  logic [$clog2(STORE_BYTES)-1:0] addr,
	input  logic [mcbf_pkg::DATA_W-1:0]    wdata,
	output logic [mcbf_pkg::DATA_W-1:0]    rdata
);
	import mcbf_pkg::*;

	logic [DATA_W-1:0] mem [STORE_BYTES];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/mcbf_ptr.sv
// Per-channel write and read positions and empty flags, with the push and
// pop decision and the store address for each transfer.
// Depends on mcbf_pkg.
module mcbf_ptr #(
	parameter int STORE_BYTES = mcbf_pkg::STORE_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  mcbf_pkg::req_item_t            req,
	input  mcbf_pkg::region_t              regions [mcbf_pkg::NUM_REGS],
	input  logic                           clear,
	output mcbf_pkg::op_res_t              res,
	output logic                           store_we,
	output logic                           store_re,
	output logic [$clog2(STORE_BYTES)-1:0] store_addr
);
	import mcbf_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);

	logic [POS_W-1:0] wp_q    [NUM_REGS];
	logic [POS_W-1:0] rp_q    [NUM_REGS];
	logic             empty_q [NUM_REGS];

	region_t           rg;
	logic [POS_W-1:0]  wp;
	logic [POS_W-1:0]  rp;
	logic              em;
	logic [POS_W-1:0]  wp_inc;
	logic [POS_W-1:0]  rp_inc;
	logic [POS_W-1:0]  wp_n;
	logic [POS_W-1:0]  rp_n;
	logic              em_n;
	logic              push_ok;
	logic              pop_ok;
	logic [END_W-1:0]  addr_sum;

	always_comb begin
		rg      = regions[req.channel];
		wp      = wp_q[req.channel];
		rp      = rp_q[req.channel];
		em      = empty_q[req.channel];
		wp_inc  = ({1'b0, wp} + 9'd1 == rg.size) ? '0 : wp + 8'd1;
		rp_inc  = ({1'b0, rp} + 9'd1 == rg.size) ? '0 : rp + 8'd1;
		push_ok = rg.usable && (req.mode == MODE_PUSH) &&
			(free_space(rg.size, wp, rp, em) != '0);
		pop_ok  = rg.usable && (req.mode == MODE_POP) && !em;
		wp_n    = wp;
		rp_n    = rp;
		em_n    = em;
		if (push_ok) begin
			wp_n = wp_inc;
			em_n = 1'b0;
		end else if (pop_ok) begin
			rp_n = rp_inc;
			em_n = (rp_inc == wp);
		end
		res.accepted = push_ok || pop_ok;
		res.pop_ok   = pop_ok;
		res.space    = rg.usable ? free_space(rg.size, wp_n, rp_n, em_n) : '0;
		addr_sum     = END_W'(rg.base) + END_W'((req.mode == MODE_PUSH) ? wp : rp);
	end

	assign store_we   = fire && push_ok;
	assign store_re   = fire && pop_ok;
	assign store_addr = AW'(addr_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_REGS; c++) begin
				wp_q[c]    <= '0;
				rp_q[c]    <= '0;
				empty_q[c] <= 1'b1;
			end
		end else if (clear) begin
			for (int c = 0; c < NUM_REGS; c++) begin
				wp_q[c]    <= '0;
				rp_q[c]    <= '0;
				empty_q[c] <= 1'b1;
			end
		end else if (fire && res.accepted) begin
			wp_q[req.channel]    <= wp_n;
			rp_q[req.channel]    <= rp_n;
			empty_q[req.channel] <= em_n;
		end
	end

	// Positions of a usable channel stay inside its region.
	a_pos_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		rg.usable |-> (({1'b0, wp} < rg.size) && ({1'b0, rp} < rg.size)))
		else $error("position outside its region");

	// An empty channel has its positions equal.
	a_empty_equal: assert property (@(posedge clk) disable iff (!arst_n)
		em |-> (wp == rp))
		else $error("empty channel with unequal positions");

	// A transfer that pops goes with a read of the store.
	a_pop_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.pop_ok) |-> (store_re && !store_we))
		else $error("accepted pop without a store read");

endmodule

### design/multi_channel_byte_fifo.sv
// Top level of the multi-channel byte FIFO: size registers, pointer table,
// shared byte store and the result pipeline with its output register.
// Depends on mcbf_pkg, mcbf_cfg, mcbf_ptr and mcbf_store.
//
//  port group  dir  handshake             payload
//  req         in   req_valid/req_ready   mode, channel, data_in
//  rsp         out  rsp_valid/rsp_ready   accepted, data_out, space_left
//  cfg         in   cfg_we                cfg_index, cfg_wdata
//
// One item is taken per cycle while req_ready is high; the store read is registered
// at the transfer, and the output register loads the result from the read stage.
// Reset clears all channels to empty and the sizes to 64 bytes; a size write
// empties every channel but keeps the stored bytes.
// A stalled output holds its result; one more item waits in the read stage, then
// req_ready drops until the output moves.
module multi_channel_byte_fifo #(
	parameter int CHANNELS    = mcbf_pkg::CHANNELS_DEF,
	parameter int STORE_BYTES = mcbf_pkg::STORE_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  mcbf_pkg::req_item_t         req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output mcbf_pkg::rsp_item_t         rsp,
	input  logic                        cfg_we,
	input  logic [mcbf_pkg::CH_W-1:0]   cfg_index,
	input  logic [mcbf_pkg::SIZE_W-1:0] cfg_wdata
);
	import mcbf_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);

	region_t           regions [NUM_REGS];
	logic              clear;
	logic              fire;
	op_res_t           res;
	logic              store_we;
	logic              store_re;
	logic [AW-1:0]     store_addr;
	logic [DATA_W-1:0] rdata;

	logic              valid_s1;
	op_res_t           res_s1;
	logic              adv_s1;
	logic              rsp_valid_q;
	rsp_item_t         rsp_q;

	mcbf_cfg #(
		.CHANNELS    (CHANNELS),
		.STORE_BYTES (STORE_BYTES)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.regions   (regions),
		.clear     (clear)
	);

	mcbf_ptr #(
		.STORE_BYTES (STORE_BYTES)
	) u_ptr (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.req        (req),
		.regions    (regions),
		.clear      (clear),
		.res        (res),
		.store_we   (store_we),
		.store_re   (store_re),
		.store_addr (store_addr)
	);

	mcbf_store #(
		.STORE_BYTES (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.re    (store_re),
		.addr  (store_addr),
		.wdata (req.data_in),
		.rdata (rdata)
	);

	assign adv_s1    = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || adv_s1;
	assign fire      = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q.accepted   <= res_s1.accepted;
			rsp_q.data_out   <= res_s1.pop_ok ? rdata : '0;
			rsp_q.space_left <= res_s1.space;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The store is never written and read in the same cycle.
	a_store_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(store_we && store_re))
		else $error("store written and read together");

	// No transfer lands on a read stage that is still holding its item.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |-> !fire)
		else $error("transfer into a stalled read stage");

	// A result that leaves the read stage is offered on the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> rsp_valid_q)
		else $error("result lost between read stage and output");

endmodule
